[rtl/rme_pkg.sv]
package rme_pkg;

  // Operand width of the arithmetic; register and port fields stay 32 bits.
  localparam int MOD_WIDTH = 32;
  localparam int FIELD_W   = 32;
  localparam int STEP_W    = $clog2(MOD_WIDTH);
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPONENT = 2'd1;

  localparam logic [FIELD_W-1:0] MODULUS_RESET  = 32'd1519187519;
  localparam logic [FIELD_W-1:0] EXPONENT_RESET = 32'd65537;

  typedef logic [MOD_WIDTH-1:0] word_t;

  // Request to the shared modular multiplier: go pulses for one cycle.
  typedef struct packed {
    logic  go;
    word_t a;
    word_t b;
  } mm_req_t;

  // Response: done pulses for one cycle with prod valid.
  typedef struct packed {
    logic  done;
    word_t prod;
  } mm_rsp_t;

endpackage

[rtl/rme_mod_mul.sv]
module rme_mod_mul (
  input  logic             clk,
  input  logic             rst_n,
  input  rme_pkg::word_t   modulus,
  input  rme_pkg::mm_req_t req,
  output rme_pkg::mm_rsp_t rsp
);
  import rme_pkg::*;

  // (x + y) mod m for x, y < m, with one spare bit for the carry.
  function automatic word_t add_mod(word_t x, word_t y, word_t m);
    logic [MOD_WIDTH:0] s;
    logic [MOD_WIDTH:0] mx;
    s  = {1'b0, x} + {1'b0, y};
    mx = {1'b0, m};
    if (s >= mx) begin
      s = s - mx;
    end
    return s[MOD_WIDTH-1:0];
  endfunction

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  word_t             a_r;
  word_t             b_r;
  word_t             r_r;
  word_t             dbl;
  word_t             r_nxt;

  // One multiplier bit per cycle, MSB first: double, then add a on a set bit.
  always_comb begin
    dbl   = add_mod(r_r, r_r, modulus);
    r_nxt = b_r[MOD_WIDTH-1] ? add_mod(dbl, a_r, modulus) : dbl;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.go) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(MOD_WIDTH - 1);
        a_r    <= req.a;
        b_r    <= req.b;
        r_r    <= '0;
      end else if (busy_r) begin
        r_r    <= r_nxt;
        b_r    <= b_r << 1;
        step_r <= step_r - 1'b1;
        if (step_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp = '{done: done_r, prod: r_r};

endmodule

[rtl/rsa_modular_exponentiation.sv]
// Modular exponentiation: result = (block ^ exponent) mod modulus.
// Input: pulse start with in_block_value while busy is low; the beat is
// taken at that edge and busy rises on the next cycle.
// Output: out_valid strobes for exactly one cycle with out_result_value.
// The receiver cannot stall; each result is presented once and dropped.
// Config: cfg_valid/cfg_ready write channel, cfg_ready is always high.
// Index 0 writes the modulus, index 1 the exponent, other indexes are
// ignored. Write only while busy is low and no strobe is pending.
// One shared shift-and-add modular multiplier does all the work, one
// multiplier bit per cycle. A beat costs one base reduction, 32 squarings
// and one multiply per set exponent bit.
// Throughput: one beat at a time; busy drops in the strobe cycle, so the
// next start can be taken there.
// A zero modulus answers 0 on the cycle after start.
// Reset: synchronous, active low; restores modulus 1519187519 and
// exponent 65537 and returns the sequencer to idle.
module rsa_modular_exponentiation (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [rme_pkg::FIELD_W-1:0]         in_block_value,
  output logic                                out_valid,
  output logic [rme_pkg::FIELD_W-1:0]         out_result_value,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rme_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rme_pkg::FIELD_W-1:0]         cfg_data
);
  import rme_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;  // wait for start
  localparam logic [1:0] ST_RED  = 2'd1;  // reduce base mod modulus
  localparam logic [1:0] ST_SQR  = 2'd2;  // acc = acc * acc
  localparam logic [1:0] ST_MUL  = 2'd3;  // acc = acc * base

  logic [1:0]         state_r, state_nxt;
  logic [FIELD_W-1:0] mod_r;
  logic [FIELD_W-1:0] exp_r;
  word_t              base_r, base_nxt;
  word_t              acc_r, acc_nxt;
  logic [STEP_W-1:0]  bit_r, bit_nxt;
  mm_req_t            req_r, req_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [FIELD_W-1:0] out_result_r, out_result_nxt;

  word_t   mod_w;
  word_t   exp_w;
  word_t   one_mod;
  mm_rsp_t rsp;
  logic    last_bit;

  assign mod_w    = MOD_WIDTH'(mod_r);
  assign exp_w    = MOD_WIDTH'(exp_r);
  // 1 mod m: zero when the modulus is one.
  assign one_mod  = (mod_w == MOD_WIDTH'(1)) ? '0 : MOD_WIDTH'(1);
  assign last_bit = (bit_r == '0);

  rme_mod_mul u_mod_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .modulus (mod_w),
    .req     (req_r),
    .rsp     (rsp)
  );

  // Left-to-right square-and-multiply over all MOD_WIDTH exponent bits.
  always_comb begin
    state_nxt      = state_r;
    base_nxt       = base_r;
    acc_nxt        = acc_r;
    bit_nxt        = bit_r;
    req_nxt        = '{go: 1'b0, a: acc_r, b: acc_r};
    out_valid_nxt  = 1'b0;
    out_result_nxt = out_result_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (mod_w == '0) begin
            // Empty modulus: answer zero at once.
            out_valid_nxt  = 1'b1;
            out_result_nxt = '0;
          end else begin
            acc_nxt   = one_mod;
            bit_nxt   = STEP_W'(MOD_WIDTH - 1);
            // Reduce the base as 1 * block mod m.
            req_nxt   = '{go: 1'b1, a: one_mod, b: MOD_WIDTH'(in_block_value)};
            state_nxt = ST_RED;
          end
        end
      end
      ST_RED: begin
        if (rsp.done) begin
          base_nxt  = rsp.prod;
          req_nxt   = '{go: 1'b1, a: acc_r, b: acc_r};
          state_nxt = ST_SQR;
        end
      end
      ST_SQR: begin
        if (rsp.done) begin
          acc_nxt = rsp.prod;
          if (exp_w[bit_r]) begin
            req_nxt   = '{go: 1'b1, a: rsp.prod, b: base_r};
            state_nxt = ST_MUL;
          end else if (last_bit) begin
            out_valid_nxt  = 1'b1;
            out_result_nxt = FIELD_W'(rsp.prod);
            state_nxt      = ST_IDLE;
          end else begin
            bit_nxt = bit_r - 1'b1;
            req_nxt = '{go: 1'b1, a: rsp.prod, b: rsp.prod};
          end
        end
      end
      ST_MUL: begin
        if (rsp.done) begin
          acc_nxt = rsp.prod;
          if (last_bit) begin
            out_valid_nxt  = 1'b1;
            out_result_nxt = FIELD_W'(rsp.prod);
            state_nxt      = ST_IDLE;
          end else begin
            bit_nxt   = bit_r - 1'b1;
            req_nxt   = '{go: 1'b1, a: rsp.prod, b: rsp.prod};
            state_nxt = ST_SQR;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      req_r       <= '0;
      out_valid_r <= 1'b0;
      mod_r       <= MODULUS_RESET;
      exp_r       <= EXPONENT_RESET;
    end else begin
      state_r     <= state_nxt;
      req_r       <= req_nxt;
      out_valid_r <= out_valid_nxt;
      // Take config beats at any time; software must write only when idle, this block does not check it.
      if (cfg_valid) begin
        case (cfg_index)
          CFG_MODULUS:  mod_r <= cfg_data;
          CFG_EXPONENT: exp_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Payload: no reset needed.
  always_ff @(posedge clk) begin
    base_r       <= base_nxt;
    acc_r        <= acc_nxt;
    bit_r        <= bit_nxt;
    out_result_r <= out_result_nxt;
  end

  assign busy             = (state_r != ST_IDLE);
  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_result_value = out_result_r;

endmodule

[rtl/rme_checker.sv]
module rme_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          out_valid,
  input logic [rme_pkg::FIELD_W-1:0]   out_result_value,
  input logic                          cfg_valid,
  input logic                          cfg_ready
);
  import rme_pkg::*;

  // A result strobe comes with the sequencer idle and a known value.
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!busy && !$isunknown(out_result_value)))
    else $error("result strobe while busy or with unknown value");

  // An accepted start either goes busy or answers at once.
  a_start_takes: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted start produced neither busy nor a result");

  // Leaving busy always delivers a result.
  a_busy_ends_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy dropped without a result strobe");

  // No result appears out of nowhere.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(busy) || $past(start)))
    else $error("result strobe without a pending item");

  // Config is never stalled.
  a_cfg_open: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("config write stalled");

endmodule

bind rsa_modular_exponentiation rme_checker u_rme_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_result_value (out_result_value),
  .cfg_valid        (cfg_valid),
  .cfg_ready        (cfg_ready)
);
